[hw/rtl/aeske_pkg.sv]
// Types, constants and GF(2^8) helpers shared by the AES key expansion files.
package aeske_pkg;

    typedef struct packed {
        logic [63:0] key_word3;
        logic [63:0] key_word2;
        logic [63:0] key_word1;
        logic [63:0] key_word0;
        logic        decrypt_keys;
        logic [1:0]  func;
    } t_key_req;

    typedef struct packed {
        logic        last_key;
        logic [63:0] round_key_high;
        logic [63:0] round_key_low;
        logic [3:0]  round_index;
    } t_round_key;

    localparam logic [1:0] FUNC_AES128 = 2'd0;
    localparam logic [1:0] FUNC_AES192 = 2'd1;
    localparam logic [1:0] FUNC_AES256 = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1b;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int j = 0; j < 4; j++) begin
            a[j]  = w[8*j +: 8];
            x2[j] = xtime(a[j]);
            x4[j] = xtime(x2[j]);
            x8[j] = xtime(x4[j]);
            m9[j] = x8[j] ^ a[j];
            mb[j] = x8[j] ^ x2[j] ^ a[j];
            md[j] = x8[j] ^ x4[j] ^ a[j];
            me[j] = x8[j] ^ x4[j] ^ x2[j];
        end
        inv_mix_word = {mb[0] ^ md[1] ^ m9[2] ^ me[3],
                        md[0] ^ m9[1] ^ me[2] ^ mb[3],
                        m9[0] ^ me[1] ^ mb[2] ^ md[3],
                        me[0] ^ mb[1] ^ md[2] ^ m9[3]};
    endfunction

endpackage

[hw/rtl/aeske_word_unit.sv]
// Shared key-schedule word unit: one new schedule word from its two source words.
module aeske_word_unit (
    input  logic [31:0] i_prev,
    input  logic [31:0] i_back,
    input  logic [7:0]  i_rcon,
    input  logic        i_rot_sub,
    input  logic        i_sub,
    output logic [31:0] o_word
);
    logic [31:0] w_t;

    always_comb begin
        priority if (i_rot_sub) begin
            w_t = aeske_pkg::sub_word({i_prev[7:0], i_prev[31:8]}) ^ {24'h0, i_rcon};
        end else if (i_sub) begin
            w_t = aeske_pkg::sub_word(i_prev);
        end else begin
            w_t = i_prev;
        end
    end

    assign o_word = i_back ^ w_t;
endmodule

[hw/rtl/aeske_imix_unit.sv]
// InvMixColumns over the four columns of one round key, bypassed when not selected.
module aeske_imix_unit (
    input  logic [127:0] i_key,
    input  logic         i_apply,
    output logic [127:0] o_key
);
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            o_key[32*j +: 32] = i_apply ? aeske_pkg::inv_mix_word(i_key[32*j +: 32])
                                        : i_key[32*j +: 32];
        end
    end
endmodule

[hw/rtl/aes_key_expansion.sv]
// AES key expansion top level: sequencer, word window and output register.
// A request with selector 0, 1 or 2 (128, 192 or 256-bit key) is expanded one schedule
// word per cycle through the shared word unit, unless a waiting round key holds it. The
// first Nk words come straight from the key and the rest from the unit, so 4*(Nr+1)
// words are produced (44, 52 or 60). A round key is complete every fourth word. A
// finished round key holds the sequencer while the previous one is still waiting. The
// block is not ready from the accepting edge until the last round key has been taken,
// so the next request is accepted in the cycle after that at the earliest. A selector
// of 3 is accepted and dropped without results.
module aes_key_expansion (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  aeske_pkg::t_key_req    i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output aeske_pkg::t_round_key  o_data
);
    logic [31:0] r_win [8];
    logic [31:0] n_win [8];
    logic [31:0] r_kbuf [8];
    logic        r_busy, n_busy;
    logic [5:0]  r_idx, n_idx;
    logic [3:0]  r_round, n_round;
    logic [7:0]  r_rcon, n_rcon;
    logic [2:0]  r_nk;
    logic [3:0]  r_nr;
    logic        r_dec;
    logic [2:0]  r_pos, n_pos;
    logic [1:0]  r_fill, n_fill;
    logic [95:0] r_rk, n_rk;
    logic        r_ovalid, n_ovalid;
    aeske_pkg::t_round_key r_odata, n_odata;

    logic [31:0]  w_new;
    logic [31:0]  w_back;
    logic [31:0]  w_word;
    logic [127:0] w_mixed;
    logic         w_step;
    logic         w_from_key;
    logic         w_accept;

    // window holds last 8 words, r_win[7] newest; Nk of eight is kept as zero
    assign w_back     = r_win[3'd0 - r_nk];
    assign w_from_key = r_idx < ((r_nk == 3'd0) ? 6'd8 : {3'd0, r_nk});
    assign w_word     = w_from_key ? r_kbuf[r_idx[2:0]] : w_new;
    assign w_step     = r_busy && (!r_ovalid || i_ready || r_fill != 2'd3);

    aeske_word_unit u_word (
        .i_prev    (r_win[7]),
        .i_back    (w_back),
        .i_rcon    (r_rcon),
        .i_rot_sub (!w_from_key && r_pos == 3'd0),
        .i_sub     (r_nk == 3'd0 && r_pos == 3'd4),
        .o_word    (w_new)
    );

    aeske_imix_unit u_imix (
        .i_key   ({w_word, r_rk}),
        .i_apply (r_dec && r_round != 4'd0 && r_round != r_nr),
        .o_key   (w_mixed)
    );

    assign o_ready  = !r_busy && !r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_win    = r_win;
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_round  = r_round;
        n_rcon   = r_rcon;
        n_pos    = r_pos;
        n_fill   = r_fill;
        n_rk     = r_rk;
        n_ovalid = r_ovalid && !i_ready;
        n_odata  = r_odata;
        if (w_step) begin
            for (int i = 0; i < 7; i++) begin
                n_win[i] = r_win[i + 1];
            end
            n_win[7] = w_word;
            if (!w_from_key && r_pos == 3'd0) begin
                n_rcon = aeske_pkg::xtime(r_rcon);
            end
            n_pos  = (r_pos == r_nk - 3'd1) ? 3'd0 : r_pos + 3'd1;
            n_fill = r_fill + 2'd1;
            n_idx  = r_idx + 6'd1;
            unique case (r_fill)
                2'd0: n_rk[31:0]  = w_word;
                2'd1: n_rk[63:32] = w_word;
                2'd2: n_rk[95:64] = w_word;
                2'd3: begin
                    n_ovalid = 1'b1;
                    n_odata.round_index    = r_round;
                    n_odata.round_key_low  = w_mixed[63:0];
                    n_odata.round_key_high = w_mixed[127:64];
                    n_odata.last_key       = (r_round == r_nr);
                    n_round = r_round + 4'd1;
                    if (r_round == r_nr) begin
                        n_busy  = 1'b0;
                        n_round = 4'd0;
                        n_rcon  = aeske_pkg::RCON_INIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_round  <= 4'd0;
            r_rcon   <= aeske_pkg::RCON_INIT;
            r_idx    <= 6'd0;
            r_pos    <= 3'd0;
            r_fill   <= 2'd0;
            r_nk     <= 3'd4;
            r_nr     <= 4'd10;
            r_dec    <= 1'b0;
            r_rk     <= '0;
            r_odata  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_win[i]  <= 32'h0;
                r_kbuf[i] <= 32'h0;
            end
        end else if (w_accept && i_data.func != aeske_pkg::FUNC_NONE) begin
            r_busy    <= 1'b1;
            r_dec     <= i_data.decrypt_keys;
            r_rcon    <= aeske_pkg::RCON_INIT;
            r_idx     <= 6'd0;
            r_pos     <= 3'd0;
            r_fill    <= 2'd0;
            r_round   <= 4'd0;
            r_kbuf[0] <= i_data.key_word0[31:0];
            r_kbuf[1] <= i_data.key_word0[63:32];
            r_kbuf[2] <= i_data.key_word1[31:0];
            r_kbuf[3] <= i_data.key_word1[63:32];
            r_kbuf[4] <= i_data.key_word2[31:0];
            r_kbuf[5] <= i_data.key_word2[63:32];
            r_kbuf[6] <= i_data.key_word3[31:0];
            r_kbuf[7] <= i_data.key_word3[63:32];
            unique case (i_data.func)
                aeske_pkg::FUNC_AES128: begin r_nk <= 3'd4; r_nr <= 4'd10; end
                aeske_pkg::FUNC_AES192: begin r_nk <= 3'd6; r_nr <= 4'd12; end
                default:                begin r_nk <= 3'd0; r_nr <= 4'd14; end
            endcase
        end else begin
            r_ovalid <= n_ovalid;
            r_busy   <= n_busy;
            r_round  <= n_round;
            r_rcon   <= n_rcon;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_fill   <= n_fill;
            r_rk     <= n_rk;
            r_odata  <= n_odata;
            r_win    <= n_win;
        end
    end
endmodule

[hw/rtl/aeske_checker.sv]
// Port-level checker for the AES key expansion, bound to the top level.
module aeske_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input aeske_pkg::t_round_key o_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result pending");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.round_index <= 4'd14)
        else $error("round index out of range");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last_key |=> !o_valid)
        else $error("result after last key");
endmodule

bind aes_key_expansion aeske_checker u_aeske_checker (.*);
